FILE: design/wildcard_fragment_signature_scan_top_defines.svh
// Assertion macros for the wildcard fragment signature scanner.
// Used by the top level; needs no other file.
`ifndef WILDCARD_FRAGMENT_SIGNATURE_SCAN_TOP_DEFINES_SVH
`define WILDCARD_FRAGMENT_SIGNATURE_SCAN_TOP_DEFINES_SVH
// Property checked each rising edge, masked during reset.
`define WFSS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Same, but also checked while reset is applied.
`define WFSS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

FILE: design/wfss_pkg.sv
// Shared constants and codes of the wildcard fragment signature scanner.
// No dependencies.
package wfss_pkg;
    localparam int MAX_FRAGMENTS    = 8;
    localparam int MAX_FRAGMENT_LEN = 32;
    localparam int POSITION_BITS    = 16;
    localparam int TOK_W    = 9;
    localparam int ROW_W    = TOK_W * MAX_FRAGMENT_LEN;
    localparam int ROW_AW   = $clog2(MAX_FRAGMENTS);
    localparam int LANE_AW  = $clog2(MAX_FRAGMENT_LEN);
    localparam int LEN_W    = $clog2(MAX_FRAGMENT_LEN + 1);
    localparam int CNT_W    = $clog2(MAX_FRAGMENTS + 1);
    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_SCAN   = 2'd2;
endpackage

FILE: design/wildcard_fragment_signature_scan_top.sv
// A result enters the output register in the cycle after the last byte.
// Throughput: one item per cycle unless stalled; the token row of the sought
// fragment is read registered from the token RAM at the next fragment index.
// Input is stalled only while an untaken result sits in the output register.
// Reset (i_rst_n low, synchronous) clears signature lengths, scan state, output valid.
// Token RAM contents are not cleared; only written tokens are ever compared.
module wildcard_fragment_signature_scan_top
    import wfss_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [7:0] byte_value, [8] is_wildcard,
                                     // [9] starts_fragment, [15:10] zero
    input  logic [1:0]  i_s_tuser,   // [1:0] command
    input  logic        i_s_tlast,   // last_byte
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata    // [0] found, [16:1] first_offset,
                                     // [17] overflow, [23:18] zero
);
`include "wildcard_fragment_signature_scan_top_defines.svh"

    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

    logic [LEN_W-1:0]         r_lens [MAX_FRAGMENTS];
    logic [LEN_W-1:0]         n_lens [MAX_FRAGMENTS];
    logic [CNT_W-1:0]         r_cnt, n_cnt, r_cur, n_cur;
    logic [7:0]               r_win [MAX_FRAGMENT_LEN];
    logic [7:0]               n_win [MAX_FRAGMENT_LEN];
    logic [POSITION_BITS-1:0] r_pos, n_pos, r_start, n_start;
    logic [LEN_W-1:0]         r_bsb, n_bsb;
    logic                     r_rec, n_rec, r_ovf, n_ovf, r_blk, n_blk;
    logic                     r_oval, n_oval;
    logic [23:0]              r_odata, n_odata;

    logic                     acc, we, hit, found;
    logic [ROW_AW-1:0]        wrow;
    logic [LANE_AW-1:0]       wlane;
    logic [ROW_W-1:0]         row;
    logic [8*MAX_FRAGMENT_LEN-1:0] win_flat;
    logic [LEN_W-1:0]         len;
    logic [CNT_W-1:0]         last_f;

    assign o_s_tready = !r_oval || i_m_tready;
    assign acc        = i_s_tvalid && o_s_tready;

    // shifted window as seen by the compare
    always_comb begin
        for (int k = 1; k < MAX_FRAGMENT_LEN; k++) begin
            win_flat[k*8 +: 8] = r_win[k-1];
        end
        win_flat[7:0] = i_s_tdata[7:0];
    end

    assign len    = r_lens[r_cur[ROW_AW-1:0]];
    assign last_f = r_cnt - CNT_W'(1);

    wfss_token_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_wrow  (wrow),
        .i_wlane (wlane),
        .i_wtok  (i_s_tdata[8:0]),
        .i_rrow  (n_cur[ROW_AW-1:0]),
        .o_rdata (row)
    );

    wfss_compare u_cmp (
        .i_row (row),
        .i_win (win_flat),
        .i_len (len),
        .o_hit (hit)
    );

    // next state
    always_comb begin
        n_lens  = r_lens;
        n_cnt   = r_cnt;
        n_cur   = r_cur;
        n_win   = r_win;
        n_pos   = r_pos;
        n_start = r_start;
        n_bsb   = r_bsb;
        n_rec   = r_rec;
        n_ovf   = r_ovf;
        n_blk   = r_blk;
        n_oval  = r_oval && !i_m_tready;
        n_odata = r_odata;
        we      = 1'b0;
        wrow    = '0;
        wlane   = '0;
        found   = 1'b0;
        if (acc) begin
            case (i_s_tuser)
                CMD_CLEAR: begin
                    for (int f = 0; f < MAX_FRAGMENTS; f++) n_lens[f] = '0;
                    for (int k = 0; k < MAX_FRAGMENT_LEN; k++) n_win[k] = '0;
                    n_cnt = '0; n_cur = '0; n_pos = '0; n_start = '0;
                    n_bsb = '0; n_rec = 1'b0; n_ovf = 1'b0; n_blk = 1'b0;
                end
                CMD_APPEND: begin
                    if (i_s_tdata[9] || r_cnt == '0) begin
                        if (r_cnt >= CNT_W'(MAX_FRAGMENTS)) begin
                            n_blk = 1'b1;
                            n_ovf = 1'b1;
                        end else begin
                            we    = 1'b1;
                            wrow  = r_cnt[ROW_AW-1:0];
                            n_lens[r_cnt[ROW_AW-1:0]] = LEN_W'(1);
                            n_cnt = r_cnt + CNT_W'(1);
                            n_blk = 1'b0;
                        end
                    end else if (r_blk) begin
                        n_ovf = 1'b1;
                    end else if (r_lens[last_f[ROW_AW-1:0]] >= LEN_W'(MAX_FRAGMENT_LEN)) begin
                        n_ovf = 1'b1;
                    end else begin
                        we    = 1'b1;
                        wrow  = last_f[ROW_AW-1:0];
                        wlane = r_lens[last_f[ROW_AW-1:0]][LANE_AW-1:0];
                        n_lens[last_f[ROW_AW-1:0]] =
                            r_lens[last_f[ROW_AW-1:0]] + LEN_W'(1);
                    end
                end
                CMD_SCAN: begin
                    for (int k = 0; k < MAX_FRAGMENT_LEN; k++) begin
                        n_win[k] = win_flat[k*8 +: 8];
                    end
                    if (r_pos >= POS_MAX) n_ovf = 1'b1;
                    else                  n_pos = r_pos + POSITION_BITS'(1);
                    n_bsb = (r_bsb < LEN_W'(MAX_FRAGMENT_LEN)) ? r_bsb + LEN_W'(1) : r_bsb;
                    if (r_cur < r_cnt && len != '0 && n_bsb >= len && hit) begin
                        if (!r_rec) begin
                            n_start = r_pos - POSITION_BITS'(len - LEN_W'(1));
                            n_rec   = 1'b1;
                        end
                        n_cur = r_cur + CNT_W'(1);
                        n_bsb = '0;
                    end
                    if (i_s_tlast) begin
                        found   = r_cnt != '0 && n_cur == r_cnt;
                        n_oval  = 1'b1;
                        n_odata = {6'd0, n_ovf, found ? n_start[15:0] : 16'd0, found};
                        for (int k = 0; k < MAX_FRAGMENT_LEN; k++) n_win[k] = '0;
                        n_pos = '0; n_bsb = '0; n_cur = '0;
                        n_start = '0; n_rec = 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int f = 0; f < MAX_FRAGMENTS; f++) r_lens[f] <= '0;
            for (int k = 0; k < MAX_FRAGMENT_LEN; k++) r_win[k] <= '0;
            r_cnt <= '0; r_cur <= '0; r_pos <= '0; r_start <= '0;
            r_bsb <= '0; r_rec <= 1'b0; r_ovf <= 1'b0; r_blk <= 1'b0;
            r_oval <= 1'b0;
        end else begin
            r_lens <= n_lens; r_win <= n_win;
            r_cnt <= n_cnt; r_cur <= n_cur; r_pos <= n_pos; r_start <= n_start;
            r_bsb <= n_bsb; r_rec <= n_rec; r_ovf <= n_ovf; r_blk <= n_blk;
            r_oval <= n_oval;
        end
    end

    always_ff @(posedge i_clk) begin
        r_odata <= n_odata;
    end

    assign o_m_tvalid = r_oval;
    assign o_m_tdata  = r_odata;

    `WFSS_ASSERT(a_cnt_range, i_clk, i_rst_n, r_cnt <= CNT_W'(MAX_FRAGMENTS), "fragment count beyond store")
    `WFSS_ASSERT(a_cur_le_cnt, i_clk, i_rst_n, r_cur <= r_cnt, "sought fragment beyond count")
    `WFSS_ASSERT(a_end_clears, i_clk, i_rst_n, acc && i_s_tuser == CMD_SCAN && i_s_tlast |=> r_pos == '0 && r_cur == '0 && o_m_tvalid, "scan state not cleared after result")
endmodule

FILE: design/wfss_token_ram.sv
// Pattern token store: one row per fragment, one token lane written at a time.
// Registered row read with write-to-read forwarding; uses wfss_pkg.
module wfss_token_ram
    import wfss_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [ROW_AW-1:0]    i_wrow,
    input  logic [LANE_AW-1:0]   i_wlane,
    input  logic [TOK_W-1:0]     i_wtok,
    input  logic [ROW_AW-1:0]    i_rrow,
    output logic [ROW_W-1:0]     o_rdata
);
    logic [ROW_W-1:0] mem [MAX_FRAGMENTS];
    logic [ROW_W-1:0] r_rdata;
    logic [ROW_W-1:0] fwd_row;

    // lane write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_wrow][i_wlane*TOK_W +: TOK_W] <= i_wtok;
        end
    end

    // read row, merging a same-cycle lane write into it
    always_comb begin
        fwd_row = mem[i_rrow];
        if (i_we && i_wrow == i_rrow) begin
            fwd_row[i_wlane*TOK_W +: TOK_W] = i_wtok;
        end
    end

    // registered row read
    always_ff @(posedge i_clk) begin
        r_rdata <= fwd_row;
    end

    assign o_rdata = r_rdata;
endmodule

FILE: design/wfss_compare.sv
// Parallel compare of one fragment row against the history window.
// Uses wfss_pkg.
module wfss_compare
    import wfss_pkg::*;
(
    input  logic [ROW_W-1:0]              i_row,
    input  logic [8*MAX_FRAGMENT_LEN-1:0] i_win,   // byte k = k-th newest
    input  logic [LEN_W-1:0]              i_len,
    output logic                          o_hit
);
    logic [MAX_FRAGMENT_LEN-1:0] miss;

    // token j lines up with window byte len-1-j
    always_comb begin
        for (int j = 0; j < MAX_FRAGMENT_LEN; j++) begin
            logic [LEN_W-1:0] k;
            logic [TOK_W-1:0] tok;
            k   = i_len - LEN_W'(1) - LEN_W'(j);
            tok = i_row[j*TOK_W +: TOK_W];
            miss[j] = (LEN_W'(j) < i_len) && !tok[8] &&
                      (i_win[k[LANE_AW-1:0]*8 +: 8] != tok[7:0]);
        end
    end

    assign o_hit = (miss == '0);
endmodule
